// ===== sv/apc_pkg.sv =====
// types, constants and helper functions shared by the preimage counter
`timescale 1ns / 1ps

package apc_pkg;

   localparam int REQ_NUMBER_W = 32;
   localparam int REQ_SIGMA_W  = 34;
   localparam int VALUE_W      = 18;
   localparam int WIDE_W       = 36;
   localparam int CBITS_W      = 4;
   localparam int COUNT_W      = 8;
   localparam int IMAGES_W     = 6;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 18;

   localparam logic [1:0] MODE_PAIR   = 2'd0;
   localparam logic [1:0] MODE_SQUARE = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOUND      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_BITS = 2'd1;

   localparam logic [VALUE_W-1:0] BOUND_RESET      = 18'd131072;
   localparam logic [CBITS_W-1:0] COUNT_BITS_RESET = 4'd8;
   localparam logic [CBITS_W-1:0] COUNT_BITS_MAX   = 4'd8;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_CHAIN,
      ST_CHAIN_WR,
      ST_PRIME,
      ST_SQUARE,
      ST_SQ_REC,
      ST_FIN_WR,
      ST_QUERY,
      ST_DONE
   } state_type;

   typedef enum logic {
      CAND_CHAIN,
      CAND_PRIME
   } cand_sel_type;

   typedef struct packed {
      logic         take;
      logic         clear;
      logic         set_t;
      logic         step_t;
      logic         set_s;
      logic         rec_issue;
      cand_sel_type cand_sel;
      logic         rec_write;
      logic         query;
      logic         load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic chain_ok;
      logic t_in_bound;
      logic sig_zero;
      logic prime_hit;
      logic square_ok;
      logic cand_ok;
      logic out_free;
   } dp_status_type;

   function automatic logic [COUNT_W-1:0] sat_limit(input logic [CBITS_W-1:0] cbits);
      logic [COUNT_W:0] full;
      full = (9'd1 << cbits) - 9'd1;
      if (cbits >= COUNT_BITS_MAX) begin
         sat_limit = '1;
      end else begin
         sat_limit = full[COUNT_W-1:0];
      end
   endfunction

endpackage

// ===== sv/apc_if.sv =====
// handshake channels of the preimage counter: request, response, csr write
`timescale 1ns / 1ps

interface apc_req_if
   import apc_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [1:0]              mode;
   logic [REQ_NUMBER_W-1:0] number;
   logic [REQ_SIGMA_W-1:0]  divisor_sum;
   logic [VALUE_W-1:0]      query_value;

   modport source (output valid, mode, number, divisor_sum, query_value, input ready);
   modport sink (input valid, mode, number, divisor_sum, query_value, output ready);
endinterface

interface apc_rsp_if
   import apc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [IMAGES_W-1:0] images_recorded;
   logic [COUNT_W-1:0]  count_value;

   modport source (output valid, images_recorded, count_value, input ready);
   modport sink (input valid, images_recorded, count_value, output ready);
endinterface

interface apc_csr_if
   import apc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/aliquot_preimage_counter_unit.sv =====
// Odd-preimage counter for even values under the aliquot map.
// req_ch carries one transaction per (m, sigma(m)) pair or counter query:
//   mode 0 records the chain 3*sigma-2m, 2t+sigma, ... while within bound, and
//   m+1 when sigma = m+1; mode 1 records sigma-m for composite odd squares;
//   mode 2 reads the counter of query_value; mode 3 only answers zeros.
// rsp_ch returns exactly one transaction per request: images_recorded and
// count_value. csr_ch writes bound (index 0) and count_bits (index 1) and is
// always ready; write it only while no request is in flight.
// One request is processed at a time. Each recorded value is a read then a
// write of the counter memory. The response is held in an output register,
// so a new request is accepted while the previous response waits; a stalled
// rsp_ch only holds the block at the end of the following request.
// After reset the counter memory is swept to zero, one entry per cycle, over
// all COUNT_ENTRIES entries (65536 by default); req_ch is not ready meanwhile.
`timescale 1ns / 1ps

module aliquot_preimage_counter_unit
   import apc_pkg::*;
#(
   parameter int COUNT_ENTRIES = 65536
)
(
   input logic       clock,
   input logic       reset,
   apc_req_if.sink   req_ch,
   apc_rsp_if.source rsp_ch,
   apc_csr_if.sink   csr_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_ch.ready = req_ready;

   apc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   apc_datapath #(
      .COUNT_ENTRIES (COUNT_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_number      (req_ch.number),
      .req_divisor_sum (req_ch.divisor_sum),
      .req_query_value (req_ch.query_value),
      .csr             (csr_ch),
      .rsp             (rsp_ch)
   );

endmodule

// ===== sv/apc_ctrl.sv =====
// sequencer of the preimage counter: clear sweep, chain walk, records, response
`timescale 1ns / 1ps

module apc_ctrl
   import apc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_mode,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          req_ready
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_PAIR:   state_in = ST_START;
                  MODE_SQUARE: state_in = ST_SQUARE;
                  MODE_QUERY:  state_in = ST_QUERY;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_START: begin
            state_in = status.chain_ok ? ST_CHAIN : ST_PRIME;
         end
         ST_CHAIN: begin
            if (!status.t_in_bound) begin
               state_in = ST_PRIME;
            end else if (status.cand_ok) begin
               state_in = ST_CHAIN_WR;
            end else if (status.sig_zero) begin
               state_in = ST_PRIME;
            end
         end
         ST_CHAIN_WR: begin
            state_in = status.sig_zero ? ST_PRIME : ST_CHAIN;
         end
         ST_PRIME: begin
            state_in = (status.prime_hit && status.cand_ok) ? ST_FIN_WR : ST_DONE;
         end
         ST_SQUARE: begin
            state_in = ST_SQ_REC;
         end
         ST_SQ_REC: begin
            state_in = (status.square_ok && status.cand_ok) ? ST_FIN_WR : ST_DONE;
         end
         ST_FIN_WR: begin
            state_in = ST_DONE;
         end
         ST_QUERY: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_START: begin
            cmd.set_t = 1'b1;
         end
         ST_CHAIN: begin
            cmd.cand_sel = CAND_CHAIN;
            if (status.t_in_bound) begin
               cmd.rec_issue = 1'b1;
               cmd.step_t    = !status.cand_ok && !status.sig_zero;
            end
         end
         ST_CHAIN_WR: begin
            cmd.rec_write = 1'b1;
            cmd.step_t    = !status.sig_zero;
         end
         ST_PRIME: begin
            cmd.cand_sel  = CAND_PRIME;
            cmd.rec_issue = status.prime_hit;
         end
         ST_SQUARE: begin
            cmd.set_s = 1'b1;
         end
         ST_SQ_REC: begin
            cmd.cand_sel  = CAND_CHAIN;
            cmd.rec_issue = status.square_ok;
         end
         ST_FIN_WR: begin
            cmd.rec_write = 1'b1;
         end
         ST_QUERY: begin
            cmd.query = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/apc_datapath.sv =====
// datapath of the preimage counter: operand registers, counter memory, csr, response
`timescale 1ns / 1ps

module apc_datapath
   import apc_pkg::*;
#(
   parameter int COUNT_ENTRIES = 65536
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dp_status_type           status,
   input  logic [REQ_NUMBER_W-1:0] req_number,
   input  logic [REQ_SIGMA_W-1:0]  req_divisor_sum,
   input  logic [VALUE_W-1:0]      req_query_value,
   apc_csr_if.sink                 csr,
   apc_rsp_if.source               rsp
);

   localparam int          ADDR_W    = (COUNT_ENTRIES > 1) ? $clog2(COUNT_ENTRIES) : 1;
   localparam logic [31:0] ENTRIES32 = 32'(COUNT_ENTRIES);

   logic [COUNT_W-1:0] mem [COUNT_ENTRIES];

   logic [VALUE_W-1:0]      bound_ff, bound_in;
   logic [CBITS_W-1:0]      cbits_ff, cbits_in;
   logic [REQ_NUMBER_W-1:0] m_ff, m_in;
   logic [REQ_SIGMA_W-1:0]  sig_ff, sig_in;
   logic [WIDE_W-1:0]       sig3_ff, sig3_in;
   logic [REQ_NUMBER_W:0]   m1_ff, m1_in;
   logic [VALUE_W-1:0]      q_ff, q_in;
   logic [WIDE_W-1:0]       t_ff, t_in;
   logic                    sqok_ff, sqok_in;
   logic                    qok_ff, qok_in;
   logic [IMAGES_W-1:0]     recorded_ff, recorded_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IMAGES_W-1:0]     images_ff, images_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0]      rdata_ff;

   logic [WIDE_W-1:0]    cand;
   logic [VALUE_W-2:0]   cand_idx;
   logic [31:0]          cand_idx32;
   logic [ADDR_W-1:0]    cand_addr;
   logic                 cand_ok;
   logic [VALUE_W-2:0]   q_idx;
   logic [31:0]          q_idx32;
   logic [ADDR_W-1:0]    q_addr;
   logic                 q_ok;
   logic [WIDE_W-1:0]    m2_wide;
   logic [COUNT_W-1:0]   limit;
   logic [COUNT_W-1:0]   inc_data;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [COUNT_W-1:0]   mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic                 out_free;

   // candidate image and its counter slot
   assign cand       = (cmd.cand_sel == CAND_PRIME) ? WIDE_W'(m1_ff) : t_ff;
   assign cand_idx   = cand[VALUE_W-1:1] - 17'd1;
   assign cand_idx32 = 32'(cand_idx);
   assign cand_addr  = cand_idx32[ADDR_W-1:0];
   assign cand_ok    = (cand <= WIDE_W'(bound_ff)) && (cand[VALUE_W-1:1] != '0)
                       && !cand[0] && (cand_idx32 < ENTRIES32);

   assign q_idx   = q_ff[VALUE_W-1:1] - 17'd1;
   assign q_idx32 = 32'(q_idx);
   assign q_addr  = q_idx32[ADDR_W-1:0];
   assign q_ok    = (q_ff[VALUE_W-1:1] != '0) && !q_ff[0] && (q_idx32 < ENTRIES32);

   assign m2_wide  = WIDE_W'({m_ff, 1'b0});
   assign limit    = sat_limit(cbits_ff);
   assign inc_data = (rdata_ff < limit) ? rdata_ff + 8'd1 : rdata_ff;
   assign out_free = !rsp_valid_ff || rsp.ready;

   assign status.clear_last = (clr_ff == ADDR_W'(COUNT_ENTRIES - 1));
   assign status.chain_ok   = !sig_ff[0] && (sig3_ff >= m2_wide);
   assign status.t_in_bound = (t_ff <= WIDE_W'(bound_ff));
   assign status.sig_zero   = (sig_ff == '0);
   assign status.prime_hit  = (REQ_SIGMA_W'(m1_ff) == sig_ff);
   assign status.square_ok  = sqok_ff;
   assign status.cand_ok    = cand_ok;
   assign status.out_free   = out_free;

   assign csr.ready           = 1'b1;
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.images_recorded = images_ff;
   assign rsp.count_value     = count_ff;

   always_comb begin
      bound_in     = bound_ff;
      cbits_in     = cbits_ff;
      m_in         = m_ff;
      sig_in       = sig_ff;
      sig3_in      = sig3_ff;
      m1_in        = m1_ff;
      q_in         = q_ff;
      t_in         = t_ff;
      sqok_in      = sqok_ff;
      qok_in       = qok_ff;
      recorded_in  = recorded_ff;
      addr_in      = addr_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      images_in    = images_ff;
      count_in     = count_ff;

      if (csr.valid) begin
         case (csr.index)
            CSR_BOUND:      bound_in = csr.data;
            CSR_COUNT_BITS: cbits_in = csr.data[CBITS_W-1:0];
            default:        bound_in = bound_ff;
         endcase
      end

      if (cmd.clear) begin
         clr_in = clr_ff + ADDR_W'(1);
      end

      if (cmd.take) begin
         m_in        = req_number;
         sig_in      = req_divisor_sum;
         sig3_in     = WIDE_W'(req_divisor_sum) + WIDE_W'({req_divisor_sum, 1'b0});
         m1_in       = (REQ_NUMBER_W + 1)'(req_number) + 33'd1;
         q_in        = req_query_value;
         qok_in      = 1'b0;
         sqok_in     = 1'b0;
         recorded_in = '0;
      end

      if (cmd.set_t) begin
         t_in = sig3_ff - m2_wide;
      end

      if (cmd.step_t) begin
         t_in = {t_ff[WIDE_W-2:0], 1'b0} + WIDE_W'(sig_ff);
      end

      if (cmd.set_s) begin
         t_in    = WIDE_W'(sig_ff) - WIDE_W'(m_ff);
         sqok_in = (sig_ff >= REQ_SIGMA_W'(m_ff)) && (REQ_SIGMA_W'(m1_ff) != sig_ff)
                   && (m_ff > 32'd1);
      end

      if (cmd.rec_issue && cand_ok) begin
         recorded_in = recorded_ff + 6'd1;
         addr_in     = cand_addr;
      end

      if (cmd.query) begin
         qok_in = q_ok;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         images_in    = recorded_ff;
         count_in     = qok_ff ? rdata_ff : '0;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff     <= BOUND_RESET;
         cbits_ff     <= COUNT_BITS_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bound_ff     <= bound_in;
         cbits_ff     <= cbits_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      sig_ff      <= sig_in;
      sig3_ff     <= sig3_in;
      m1_ff       <= m1_in;
      q_ff        <= q_in;
      t_ff        <= t_in;
      sqok_ff     <= sqok_in;
      qok_ff      <= qok_in;
      recorded_ff <= recorded_in;
      addr_ff     <= addr_in;
      images_ff   <= images_in;
      count_ff    <= count_in;
   end

   // counter memory, one write and one registered read a cycle
   assign mem_we    = cmd.clear || cmd.rec_write;
   assign mem_waddr = cmd.clear ? clr_ff : addr_ff;
   assign mem_wdata = cmd.clear ? '0 : inc_data;
   assign mem_re    = (cmd.rec_issue && cand_ok) || cmd.query;
   assign mem_raddr = cmd.query ? q_addr : cand_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp.ready))
      else $error("response loaded over a pending transaction");

   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !(cmd.rec_write || cmd.rec_issue || cmd.take))
      else $error("counter update during clear sweep");

   a_step_in_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step_t |-> ((sig_ff != '0) && (t_ff <= WIDE_W'(bound_ff))))
      else $error("chain stepped past bound or with zero sigma");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rec_write |-> $past(cmd.rec_issue && cand_ok))
      else $error("counter write without a preceding read");
`endif

endmodule
